@@ design/assert_macros.svh @@
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cond at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/cpr_pkg.sv @@
// Types and constants of the clock page replacement core.
package cpr_pkg;

  localparam int CFG_W      = 5;
  localparam int PAGE_IN_W  = 20;
  localparam int SLOT_OUT_W = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SWEEP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic look;
    logic wr;
    logic set_ref;
    logic step;
    logic load_tok;
    logic clr_tok;
  } ctl_t;

  typedef struct packed {
    logic match;
    logic refb;
    logic tok;
  } cell_st_t;

endpackage

@@ design/cpr_cell.sv @@
// One frame cell: resident page, reference bit, lookup match and sweep token.
module cpr_cell import cpr_pkg::*; #(
  parameter int PAGE_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_t                 ctl,
  input  logic                 sel,
  input  logic                 filled,
  input  logic [PAGE_BITS-1:0] page_in,
  input  logic                 tok_in,
  output cell_st_t             st,
  output logic [PAGE_BITS-1:0] page
);

  logic [PAGE_BITS-1:0] page_r;
  logic                 ref_r, ref_nxt;
  logic                 tok_r, tok_nxt;
  logic                 match_r, match_nxt;

  always_comb begin
    ref_nxt = ref_r;
    if ((ctl.wr || ctl.set_ref) && sel) begin
      ref_nxt = 1'b1;
    end else if (ctl.step && tok_r) begin
      ref_nxt = 1'b0;
    end
    tok_nxt = tok_r;
    if (ctl.load_tok) begin
      tok_nxt = sel;
    end else if (ctl.clr_tok) begin
      tok_nxt = 1'b0;
    end else if (ctl.step) begin
      tok_nxt = tok_in;
    end
    match_nxt = match_r;
    if (ctl.look) begin
      match_nxt = filled && (page_r == page_in);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r   <= 1'b0;
      tok_r   <= 1'b0;
      match_r <= 1'b0;
    end else begin
      ref_r   <= ref_nxt;
      tok_r   <= tok_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr && sel) begin
      page_r <= page_in;
    end
  end

  assign st.match = match_r;
  assign st.refb  = ref_r;
  assign st.tok   = tok_r;
  assign page     = page_r;

endmodule

@@ design/clock_page_replacement_core.sv @@
// Top level of the clock (second-chance) page replacement core.
// One page access per input beat, one result beat per access. The page is
// compared against every filled frame cell at the accepting edge; the next
// cycle picks the lowest match, a free frame, or starts the clock sweep. A
// hit or a fill passes from acceptance through DECIDE and EMIT back to IDLE;
// a replacement adds the SWEEP state, where a one-hot token walks the chain
// of managed cells one frame per cycle, clearing reference bits, until it
// reaches a frame whose reference bit is clear. The result waits in an
// output register; the next access is taken once the current one has been
// handed to it.
`include "assert_macros.svh"

module clock_page_replacement_core import cpr_pkg::*; #(
  parameter int NUM_FRAMES = 16,
  parameter int PAGE_BITS  = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PAGE_IN_W-1:0]  in_page_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit,
  output logic                  out_evicted,
  output logic [PAGE_IN_W-1:0]  out_evicted_page,
  output logic [SLOT_OUT_W-1:0] out_frame_slot
);

  localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int FW = $clog2(NUM_FRAMES + 1);

  logic [CFG_W-1:0]           frames_r;
  logic [FW-1:0]              m_eff;
  logic [IW-1:0]              m_last;
  state_t                     state_r, state_nxt;
  logic [FW-1:0]              filled_r, filled_nxt;
  logic [IW-1:0]              hand_r, hand_nxt, hand_inc, hand_start;
  logic [PAGE_BITS-1:0]       page_r, page_nxt;
  logic [PAGE_BITS+PAGE_IN_W-1:0] pg_ext;
  logic [PAGE_BITS-1:0]       pg_in;
  ctl_t                       ctl;
  logic [IW-1:0]              cmd_idx;
  logic [PAGE_BITS-1:0]       cell_page_in;
  cell_st_t                   cell_st [NUM_FRAMES];
  logic [PAGE_BITS-1:0]       cell_page [NUM_FRAMES];
  logic [NUM_FRAMES-1:0]      match_vec, ref_vec, tok_vec, pass_vec, tok_in_vec;
  logic [NUM_FRAMES-1:0]      sel_vec, fill_vec;
  logic                       first_hit;
  logic [IW-1:0]              first_slot;
  logic                       stop;
  logic [PAGE_BITS-1:0]       evict_page;
  logic                       res_hit_r, res_hit_nxt;
  logic                       res_ev_r, res_ev_nxt;
  logic [PAGE_BITS-1:0]       res_epage_r, res_epage_nxt;
  logic [IW-1:0]              res_slot_r, res_slot_nxt;
  logic                       out_load;
  logic                       out_valid_r;
  logic                       out_hit_r, out_ev_r;
  logic [PAGE_IN_W-1:0]       out_epage_r;
  logic [SLOT_OUT_W-1:0]      out_slot_r;
  logic [PAGE_BITS+PAGE_IN_W-1:0] epage_ext;
  logic [IW+SLOT_OUT_W-1:0]   slot_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= CFG_RESET;
    end else if (cfg_we) begin
      frames_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (frames_r == '0) begin
      m_eff = FW'(1);
    end else if (32'(frames_r) > 32'(NUM_FRAMES)) begin
      m_eff = FW'(NUM_FRAMES);
    end else begin
      m_eff = FW'(frames_r);
    end
  end

  assign m_last     = IW'(m_eff - FW'(1));
  assign hand_inc   = ((FW'(hand_r) + FW'(1)) == m_eff) ? '0 : IW'(hand_r + IW'(1));
  assign hand_start = (FW'(hand_r) >= m_eff) ? '0 : hand_r;

  assign pg_ext = {{PAGE_BITS{1'b0}}, in_page_number};
  assign pg_in  = pg_ext[PAGE_BITS-1:0];
  assign cell_page_in = ctl.look ? pg_in : page_r;

  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    assign sel_vec[i]   = (cmd_idx == IW'(i));
    assign fill_vec[i]  = (FW'(i) < filled_r);
    assign match_vec[i] = cell_st[i].match;
    assign ref_vec[i]   = cell_st[i].refb;
    assign tok_vec[i]   = cell_st[i].tok;
    assign pass_vec[i]  = cell_st[i].tok && cell_st[i].refb;
    if (i == 0) begin : g_head
      assign tok_in_vec[i] = pass_vec[m_last];
    end else begin : g_body
      assign tok_in_vec[i] = pass_vec[i-1] && (IW'(i-1) != m_last);
    end

    cpr_cell #(
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .sel     (sel_vec[i]),
      .filled  (fill_vec[i]),
      .page_in (cell_page_in),
      .tok_in  (tok_in_vec[i]),
      .st      (cell_st[i]),
      .page    (cell_page[i])
    );
  end

  always_comb begin
    first_hit  = 1'b0;
    first_slot = '0;
    evict_page = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        first_hit  = 1'b1;
        first_slot = IW'(i);
      end
    end
    for (int i = 0; i < NUM_FRAMES; i++) begin
      evict_page = evict_page | (cell_page[i] & {PAGE_BITS{tok_vec[i]}});
    end
  end

  assign stop     = |(tok_vec & ~ref_vec);
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    filled_nxt    = filled_r;
    hand_nxt      = hand_r;
    page_nxt      = page_r;
    res_hit_nxt   = res_hit_r;
    res_ev_nxt    = res_ev_r;
    res_epage_nxt = res_epage_r;
    res_slot_nxt  = res_slot_r;
    ctl           = '0;
    cmd_idx       = hand_r;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.look  = 1'b1;
          page_nxt  = pg_in;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        res_hit_nxt   = 1'b0;
        res_ev_nxt    = 1'b0;
        res_epage_nxt = '0;
        if (first_hit) begin
          ctl.set_ref  = 1'b1;
          cmd_idx      = first_slot;
          res_hit_nxt  = 1'b1;
          res_slot_nxt = first_slot;
          state_nxt    = ST_EMIT;
        end else if (filled_r < m_eff) begin
          ctl.wr       = 1'b1;
          cmd_idx      = IW'(filled_r);
          res_slot_nxt = IW'(filled_r);
          filled_nxt   = FW'(filled_r + FW'(1));
          state_nxt    = ST_EMIT;
        end else begin
          ctl.load_tok = 1'b1;
          cmd_idx      = hand_start;
          hand_nxt     = hand_start;
          state_nxt    = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        hand_nxt = hand_inc;
        if (stop) begin
          ctl.wr        = 1'b1;
          ctl.clr_tok   = 1'b1;
          res_ev_nxt    = 1'b1;
          res_epage_nxt = evict_page;
          res_slot_nxt  = hand_r;
          state_nxt     = ST_EMIT;
        end else begin
          ctl.step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      filled_r    <= '0;
      hand_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      filled_r <= filled_nxt;
      hand_r   <= hand_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign epage_ext = {{PAGE_IN_W{1'b0}}, res_epage_r};
  assign slot_ext  = {{SLOT_OUT_W{1'b0}}, res_slot_r};

  always_ff @(posedge clk) begin
    page_r      <= page_nxt;
    res_hit_r   <= res_hit_nxt;
    res_ev_r    <= res_ev_nxt;
    res_epage_r <= res_epage_nxt;
    res_slot_r  <= res_slot_nxt;
    if (out_load) begin
      out_hit_r   <= res_hit_r;
      out_ev_r    <= res_ev_r;
      out_epage_r <= epage_ext[PAGE_IN_W-1:0];
      out_slot_r  <= slot_ext[SLOT_OUT_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_evicted      = out_ev_r;
  assign out_evicted_page = out_epage_r;
  assign out_frame_slot   = out_slot_r;

  `ASSERT_ALWAYS(a_tok_onehot0, clk, rst_n, $onehot0(tok_vec), "more than one sweep token")
  `ASSERT_ALWAYS(a_tok_in_sweep, clk, rst_n, (state_r != ST_SWEEP) || $onehot(tok_vec), "sweep without exactly one token")
  `ASSERT_ALWAYS(a_hand_range, clk, rst_n, (state_r != ST_SWEEP) || (FW'(hand_r) < m_eff), "hand outside managed frames during sweep")
  `ASSERT_ALWAYS(a_filled_bound, clk, rst_n, filled_r <= FW'(NUM_FRAMES), "filled count beyond table depth")
  `ASSERT_NEXT(a_accept_decide, clk, rst_n, in_valid && in_ready, state_r == ST_DECIDE, "accepted beat not followed by decide")

endmodule
